@@ src/ttas_pkg.sv @@
// ----------------------------------------------------------------------------
// Tick task activation scheduler package
// Shared constants, codes and types of the scheduler modules.
// ----------------------------------------------------------------------------
package ttas_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int TASK_W    = IDX_W + 1;
	localparam int RUN_W     = 8;
	localparam int MASK_W    = 16;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [TASK_W-1:0] BKG_TASK = TASK_W'(MAX_TASKS);

	localparam logic [2:0] MODE_TICK     = 3'd0;
	localparam logic [2:0] MODE_DISPATCH = 3'd1;
	localparam logic [2:0] MODE_DONE     = 3'd2;
	localparam logic [2:0] MODE_ACTIVATE = 3'd3;
	localparam logic [2:0] MODE_HALT     = 3'd4;

	localparam logic [1:0] ST_SUSPENDED = 2'd0;
	localparam logic [1:0] ST_READY     = 2'd1;
	localparam logic [1:0] ST_RUNNING   = 2'd2;

	localparam logic [1:0] STATUS_RUNNING  = 2'd1;
	localparam logic [1:0] STATUS_OVERLOAD = 2'd2;
	localparam logic [1:0] STATUS_HALTED   = 2'd3;

	localparam logic [IDX_W-1:0] SLOT_1MS   = IDX_W'(0);
	localparam logic [IDX_W-1:0] SLOT_2MSA  = IDX_W'(1);
	localparam logic [IDX_W-1:0] SLOT_2MSB  = IDX_W'(2);
	localparam logic [IDX_W-1:0] SLOT_10MS  = IDX_W'(3);
	localparam logic [IDX_W-1:0] SLOT_50MS  = IDX_W'(4);
	localparam logic [IDX_W-1:0] SLOT_100MS = IDX_W'(5);

	localparam logic [6:0] HUNDRED_LIMIT = 7'd100;
	localparam logic [4:0] FIFTY_LIMIT   = 5'd25;
	localparam logic [2:0] TEN_LIMIT     = 3'd5;

	localparam logic REG_NUM_TASKS = 1'b0;
	localparam logic REG_HANDLER   = 1'b1;

	localparam logic [TASK_W-1:0] NUM_TASKS_RESET = TASK_W'(6);
	localparam logic [MASK_W-1:0] HANDLER_RESET   = 16'hFFFF;

	typedef struct packed {
		logic [IDX_W-1:0] slot_a;
		logic             has_b;
		logic [IDX_W-1:0] slot_b;
	} tick_slots_t;

	typedef struct packed {
		logic             rd_en;
		logic             st_we;
		logic             cnt_we;
		logic [IDX_W-1:0] idx;
		logic [1:0]       st_wdata;
		logic [RUN_W-1:0] cnt_wdata;
	} mem_req_t;

endpackage

@@ src/ttas_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the slot count and the handler mask.
// ----------------------------------------------------------------------------
module ttas_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ttas_pkg::ADDR_W-1:0] paddr,
	input  logic [ttas_pkg::DATA_W-1:0] pwdata,
	output logic [ttas_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output logic [ttas_pkg::TASK_W-1:0] slots_in_use,
	output logic [ttas_pkg::MASK_W-1:0] handler_mask
);
	import ttas_pkg::*;

	logic [TASK_W-1:0] num_tasks_q;
	logic [MASK_W-1:0] handler_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tasks_q <= NUM_TASKS_RESET;
			handler_q   <= HANDLER_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NUM_TASKS: num_tasks_q <= pwdata[TASK_W-1:0];
				REG_HANDLER:   handler_q   <= pwdata[MASK_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NUM_TASKS: prdata = DATA_W'(num_tasks_q);
			REG_HANDLER:   prdata = DATA_W'(handler_q);
			default:       prdata = '0;
		endcase
	end

	assign slots_in_use = (num_tasks_q > BKG_TASK) ? BKG_TASK : num_tasks_q;
	assign handler_mask = handler_q;

endmodule

@@ src/ttas_tick_gen.sv @@
// ----------------------------------------------------------------------------
// Tick phase generator
// Phase counter and period dividers that pick the slots a tick readies.
// ----------------------------------------------------------------------------
module ttas_tick_gen (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	output ttas_pkg::tick_slots_t slots
);
	import ttas_pkg::*;

	logic [7:0] phase_q;
	logic [2:0] ten_q;
	logic [4:0] fifty_q;
	logic [6:0] hundred_q;
	logic [7:0] phase_nx;
	logic [2:0] ten_nx;
	logic [4:0] fifty_nx;
	logic [6:0] hundred_nx;
	logic [2:0] ten_inc;
	logic [4:0] fifty_inc;
	logic [6:0] hundred_inc;

	always_comb begin
		phase_nx    = phase_q + 8'd1;
		ten_inc     = ten_q + 3'd1;
		fifty_inc   = fifty_q + 5'd1;
		hundred_inc = hundred_q + 7'd1;
		ten_nx      = ten_q;
		fifty_nx    = fifty_q;
		hundred_nx  = hundred_q;
		slots       = '0;
		if (phase_nx[0]) begin
			slots.slot_a = SLOT_1MS;
			if (hundred_inc >= HUNDRED_LIMIT) begin
				slots.has_b  = 1'b1;
				slots.slot_b = SLOT_100MS;
				hundred_nx   = '0;
			end else begin
				hundred_nx = hundred_inc;
			end
		end else if (phase_nx[1]) begin
			slots.slot_a = SLOT_2MSA;
			if (fifty_inc >= FIFTY_LIMIT) begin
				slots.has_b  = 1'b1;
				slots.slot_b = SLOT_50MS;
				fifty_nx     = '0;
			end else begin
				fifty_nx = fifty_inc;
			end
		end else begin
			slots.slot_a = SLOT_2MSB;
			if (ten_inc >= TEN_LIMIT) begin
				slots.has_b  = 1'b1;
				slots.slot_b = SLOT_10MS;
				ten_nx       = '0;
			end else begin
				ten_nx = ten_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			ten_q     <= '0;
			fifty_q   <= '0;
			hundred_q <= '0;
		end else if (advance) begin
			phase_q   <= phase_nx;
			ten_q     <= ten_nx;
			fifty_q   <= fifty_nx;
			hundred_q <= hundred_nx;
		end
	end

endmodule

@@ src/ttas_task_mem.sv @@
// ----------------------------------------------------------------------------
// Task state memories
// Status and run count memories with a registered read; entries that
// were never written read as their reset values.
// ----------------------------------------------------------------------------
module ttas_task_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ttas_pkg::mem_req_t        req,
	output logic [1:0]                st_rdata,
	output logic [ttas_pkg::RUN_W-1:0] cnt_rdata
);
	import ttas_pkg::*;

	logic [1:0]       st_mem  [MAX_TASKS];
	logic [RUN_W-1:0] cnt_mem [MAX_TASKS];
	logic [1:0]       st_raw_s1;
	logic [RUN_W-1:0] cnt_raw_s1;
	logic [MAX_TASKS-1:0] st_vld_q;
	logic [MAX_TASKS-1:0] cnt_vld_q;
	logic             st_vld_s1;
	logic             cnt_vld_s1;

	always_ff @(posedge clk) begin
		if (req.st_we) begin
			st_mem[req.idx] <= req.st_wdata;
		end
		if (req.cnt_we) begin
			cnt_mem[req.idx] <= req.cnt_wdata;
		end
		if (req.rd_en) begin
			st_raw_s1  <= st_mem[req.idx];
			cnt_raw_s1 <= cnt_mem[req.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q   <= '0;
			cnt_vld_q  <= '0;
			st_vld_s1  <= 1'b0;
			cnt_vld_s1 <= 1'b0;
		end else begin
			if (req.st_we) begin
				st_vld_q[req.idx] <= 1'b1;
			end
			if (req.cnt_we) begin
				cnt_vld_q[req.idx] <= 1'b1;
			end
			if (req.rd_en) begin
				st_vld_s1  <= st_vld_q[req.idx];
				cnt_vld_s1 <= cnt_vld_q[req.idx];
			end
		end
	end

	assign st_rdata  = st_vld_s1 ? st_raw_s1 : ST_SUSPENDED;
	assign cnt_rdata = cnt_vld_s1 ? cnt_raw_s1 : '0;

endmodule

@@ src/ttas_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Event decode, read-modify-write of the task memories, dispatch scan and
// result register.
// ----------------------------------------------------------------------------
module ttas_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [2:0]                  mode,
	input  logic [ttas_pkg::IDX_W-1:0]  task_index,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        found,
	output logic [ttas_pkg::IDX_W-1:0]  dispatched_task,
	output logic [ttas_pkg::RUN_W-1:0]  dispatched_run_count,
	output logic [ttas_pkg::TASK_W-1:0] running_task,
	output logic [ttas_pkg::MASK_W-1:0] overload_mask,
	output logic [1:0]                  scheduler_status,
	input  logic [ttas_pkg::TASK_W-1:0] slots_in_use,
	input  logic [ttas_pkg::MASK_W-1:0] handler_mask,
	input  ttas_pkg::tick_slots_t       slots,
	output logic                        tick_advance,
	output ttas_pkg::mem_req_t          mem_req,
	input  logic [1:0]                  st_rdata,
	input  logic [ttas_pkg::RUN_W-1:0]  cnt_rdata
);
	import ttas_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_TICK2  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]        state_q;
	logic [2:0]        state_nx;
	logic [2:0]        mode_q;
	logic [IDX_W-1:0]  index_q;
	logic [TASK_W-1:0] cur_task_q;
	logic [TASK_W-1:0] sweep_q;
	logic [TASK_W-1:0] scan_q;
	logic [1:0]        status_q;
	logic [MASK_W-1:0] ovl_q;
	logic [IDX_W-1:0]  slot_b_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_task_q;
	logic [RUN_W-1:0]  res_cnt_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [IDX_W-1:0]  out_task_q;
	logic [RUN_W-1:0]  out_cnt_q;
	logic [TASK_W-1:0] out_running_q;
	logic [MASK_W-1:0] out_ovl_q;
	logic [1:0]        out_status_q;
	logic              out_load;
	logic              ready_slot;
	logic [IDX_W-1:0]  ready_idx;
	logic              hit;
	logic [RUN_W-1:0]  cnt_inc;

	assign item_ready = (state_q == S_IDLE);
	assign out_load   = (state_q == S_FINISH) && (!out_valid_q || result_ready);
	assign hit        = (st_rdata == ST_READY) && handler_mask[scan_q[IDX_W-1:0]];
	assign cnt_inc    = cnt_rdata + RUN_W'(1);

	always_comb begin
		state_nx     = state_q;
		mem_req      = '0;
		tick_advance = 1'b0;
		ready_slot   = 1'b0;
		ready_idx    = slots.slot_a;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nx = S_FINISH;
				unique case (mode_q)
					MODE_TICK: begin
						tick_advance = 1'b1;
						ready_slot   = 1'b1;
						ready_idx    = slots.slot_a;
						if (slots.has_b) begin
							state_nx = S_TICK2;
						end
					end
					MODE_DISPATCH: begin
						if (cur_task_q == BKG_TASK) begin
							state_nx = S_SCAN;
						end
					end
					MODE_DONE: begin
						if (!cur_task_q[TASK_W-1]) begin
							mem_req.st_we    = 1'b1;
							mem_req.idx      = cur_task_q[IDX_W-1:0];
							mem_req.st_wdata = ST_SUSPENDED;
						end
					end
					MODE_ACTIVATE: begin
						if ({1'b0, index_q} < slots_in_use) begin
							mem_req.st_we    = 1'b1;
							mem_req.idx      = index_q;
							mem_req.st_wdata = ST_READY;
						end
					end
					default: ;
				endcase
			end
			S_TICK2: begin
				ready_slot = 1'b1;
				ready_idx  = slot_b_q;
				state_nx   = S_FINISH;
			end
			S_SCAN: begin
				if (scan_q < slots_in_use) begin
					mem_req.rd_en = 1'b1;
					mem_req.idx   = scan_q[IDX_W-1:0];
					state_nx      = S_CHECK;
				end else begin
					state_nx = S_FINISH;
				end
			end
			S_CHECK: begin
				if (hit) begin
					mem_req.st_we     = 1'b1;
					mem_req.cnt_we    = 1'b1;
					mem_req.idx       = scan_q[IDX_W-1:0];
					mem_req.st_wdata  = ST_RUNNING;
					mem_req.cnt_wdata = cnt_inc;
					state_nx          = S_FINISH;
				end else begin
					state_nx = S_SCAN;
				end
			end
			S_FINISH: begin
				if (out_load) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		if (ready_slot && ({1'b0, ready_idx} < slots_in_use)) begin
			mem_req.st_we    = 1'b1;
			mem_req.idx      = ready_idx;
			mem_req.st_wdata = ST_READY;
		end else begin
			ready_slot = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_task_q  <= BKG_TASK;
			sweep_q     <= '0;
			scan_q      <= '0;
			status_q    <= STATUS_RUNNING;
			ovl_q       <= '0;
			res_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ready_slot && ({1'b0, ready_idx} == cur_task_q)) begin
				ovl_q[ready_idx] <= 1'b1;
				status_q         <= STATUS_OVERLOAD;
			end
			unique case (state_q)
				S_EXEC: begin
					res_found_q <= 1'b0;
					unique case (mode_q)
						MODE_DISPATCH: scan_q <= sweep_q;
						MODE_DONE: begin
							if (!cur_task_q[TASK_W-1]) begin
								cur_task_q <= BKG_TASK;
							end
						end
						MODE_HALT: status_q <= STATUS_HALTED;
						default: ;
					endcase
				end
				S_SCAN: begin
					if (scan_q >= slots_in_use) begin
						sweep_q <= '0;
					end
				end
				S_CHECK: begin
					if (hit) begin
						cur_task_q  <= scan_q;
						sweep_q     <= scan_q + TASK_W'(1);
						res_found_q <= 1'b1;
					end else begin
						scan_q <= scan_q + TASK_W'(1);
					end
				end
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			mode_q  <= mode;
			index_q <= task_index;
		end
		if (state_q == S_EXEC) begin
			slot_b_q   <= slots.slot_b;
			res_task_q <= '0;
			res_cnt_q  <= '0;
		end
		if (state_q == S_CHECK && hit) begin
			res_task_q <= scan_q[IDX_W-1:0];
			res_cnt_q  <= cnt_inc;
		end
		if (out_load) begin
			out_found_q   <= res_found_q;
			out_task_q    <= res_task_q;
			out_cnt_q     <= res_cnt_q;
			out_running_q <= cur_task_q;
			out_ovl_q     <= ovl_q;
			out_status_q  <= status_q;
		end
	end

	assign result_valid         = out_valid_q;
	assign found                = out_found_q;
	assign dispatched_task      = out_task_q;
	assign dispatched_run_count = out_cnt_q;
	assign running_task         = out_running_q;
	assign overload_mask        = out_ovl_q;
	assign scheduler_status     = out_status_q;

	a_task_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_task_q <= BKG_TASK)
		else $error("Running task index is out of range.");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q <= BKG_TASK)
		else $error("Sweep position is out of range.");

	a_check_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> $past(state_q) == S_SCAN)
		else $error("Status check without a preceding memory read.");

	a_found_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_found_q |-> cur_task_q == {1'b0, res_task_q})
		else $error("Dispatched task is not the running task.");

endmodule

@@ src/tick_task_activation_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Tick task activation scheduler
// Time-triggered cooperative scheduler: ticks ready periodic slots, dispatch
// starts the next ready task with a handler.
// ----------------------------------------------------------------------------
// Each event transaction is handled one at a time. A plain event passes from the
// idle state through the execute state to the finish state, which loads the
// output register; a tick whose phase also calls for a second slot passes through
// a second tick state as well. A dispatch while no task runs walks the status
// memory from the sweep position, and each slot it examines takes a scan state
// for the registered memory read and a check state, until it starts a ready slot
// with a handler or passes the last slot in use. The next event is taken once
// the result is in the output register, while that result still waits; a result
// that is still waiting holds the following one back.
// All state memories start out cleared; there is no clearing pass.
module tick_task_activation_scheduler_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ttas_pkg::ADDR_W-1:0] paddr,
	input  logic [ttas_pkg::DATA_W-1:0] pwdata,
	output logic [ttas_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [2:0]                  mode,
	input  logic [3:0]                  task_index,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        found,
	output logic [3:0]                  dispatched_task,
	output logic [7:0]                  dispatched_run_count,
	output logic [4:0]                  running_task,
	output logic [15:0]                 overload_mask,
	output logic [1:0]                  scheduler_status
);
	import ttas_pkg::*;

	logic [TASK_W-1:0] slots_in_use;
	logic [MASK_W-1:0] handler_mask;
	tick_slots_t       slots;
	logic              tick_advance;
	mem_req_t          mem_req;
	logic [1:0]        st_rdata;
	logic [RUN_W-1:0]  cnt_rdata;

	ttas_cfg_regs u_cfg_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.slots_in_use (slots_in_use),
		.handler_mask (handler_mask)
	);

	ttas_tick_gen u_tick_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (tick_advance),
		.slots   (slots)
	);

	ttas_task_mem u_task_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mem_req),
		.st_rdata  (st_rdata),
		.cnt_rdata (cnt_rdata)
	);

	ttas_ctrl u_ctrl (
		.clk                  (clk),
		.arst_n               (arst_n),
		.item_valid           (item_valid),
		.item_ready           (item_ready),
		.mode                 (mode),
		.task_index           (task_index),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.found                (found),
		.dispatched_task      (dispatched_task),
		.dispatched_run_count (dispatched_run_count),
		.running_task         (running_task),
		.overload_mask        (overload_mask),
		.scheduler_status     (scheduler_status),
		.slots_in_use         (slots_in_use),
		.handler_mask         (handler_mask),
		.slots                (slots),
		.tick_advance         (tick_advance),
		.mem_req              (mem_req),
		.st_rdata             (st_rdata),
		.cnt_rdata            (cnt_rdata)
	);

endmodule

@@ bench/tb_tick_task_activation_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Testbench for the tick task activation scheduler
// Drives event transactions through the valid/ready input, predicts each
// result with a cycle-free model of the scheduler state, and checks every
// result field. Register settings change between phases while the block is
// idle; the sender bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_tick_task_activation_scheduler_unit;
	import ttas_pkg::*;

	localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
	localparam int         LONG_HOLD        = 300;
	localparam int         SETTLE_CYCLES    = 50;

	typedef struct {
		logic [2:0] op;
		logic [3:0] slot;
	} sched_event_t;

	typedef struct {
		logic        found;
		logic [3:0]  task_id;
		logic [7:0]  runs;
		logic [4:0]  running;
		logic [15:0] overload;
		logic [1:0]  status;
	} sched_result_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              psel           = 1'b0;
	logic              penable        = 1'b0;
	logic              pwrite         = 1'b0;
	logic [ADDR_W-1:0] paddr          = '0;
	logic [DATA_W-1:0] pwdata         = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid     = 1'b0;
	logic              item_ready;
	logic [2:0]        mode           = MODE_TICK;
	logic [3:0]        task_index     = '0;
	logic              result_valid;
	logic              result_ready   = 1'b0;
	logic              found;
	logic [3:0]        dispatched_task;
	logic [7:0]        dispatched_run_count;
	logic [4:0]        running_task;
	logic [15:0]       overload_mask;
	logic [1:0]        scheduler_status;

	logic              sender_bursty  = 1'b0;
	logic              receiver_stalls = 1'b0;
	int                hold_requests  = 0;

	sched_event_t      pending_events[$];
	sched_result_t     expected_results[$];
	int                events_queued  = 0;
	int                mismatches     = 0;
	int                results_checked = 0;
	int                settings_run   = 0;
	int                ticks_applied  = 0;
	int                dispatch_hits  = 0;

	// Predicted scheduler state and register copies.
	logic [4:0]        cfg_slots;
	logic [15:0]       cfg_handlers;
	logic [7:0]        phase_ctr;
	logic [2:0]        four_ctr;
	logic [4:0]        two_ctr;
	logic [6:0]        odd_ctr;
	logic [1:0]        slot_state[MAX_TASKS];
	logic [7:0]        run_ctr[MAX_TASKS];
	logic [15:0]       overload_bits;
	logic [4:0]        running_slot;
	logic [4:0]        sweep_ptr;
	logic [1:0]        sched_status;

	tick_task_activation_scheduler_unit dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.item_valid           (item_valid),
		.item_ready           (item_ready),
		.mode                 (mode),
		.task_index           (task_index),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.found                (found),
		.dispatched_task      (dispatched_task),
		.dispatched_run_count (dispatched_run_count),
		.running_task         (running_task),
		.overload_mask        (overload_mask),
		.scheduler_status     (scheduler_status)
	);

	always #5 clk = ~clk;

	function automatic void clear_schedule();
		cfg_slots     = NUM_TASKS_RESET;
		cfg_handlers  = HANDLER_RESET;
		phase_ctr     = '0;
		four_ctr      = '0;
		two_ctr       = '0;
		odd_ctr       = '0;
		overload_bits = '0;
		running_slot  = BKG_TASK;
		sweep_ptr     = '0;
		sched_status  = STATUS_RUNNING;
		for (int i = 0; i < MAX_TASKS; i++) begin
			slot_state[i] = ST_SUSPENDED;
			run_ctr[i]    = '0;
		end
	endfunction

	function automatic int slots_active();
		return (cfg_slots > MAX_TASKS) ? MAX_TASKS : int'(cfg_slots);
	endfunction

	function automatic void ready_slot(input int s);
		if (s >= slots_active())
			return;
		slot_state[s] = ST_READY;
		if (s == int'(running_slot)) begin
			overload_bits[s] = 1'b1;
			sched_status     = STATUS_OVERLOAD;
		end
	endfunction

	function automatic void advance_tick();
		phase_ctr = phase_ctr + 8'd1;
		ticks_applied++;
		if (phase_ctr[0]) begin
			odd_ctr = odd_ctr + 7'd1;
			ready_slot(SLOT_1MS);
			if (odd_ctr >= HUNDRED_LIMIT) begin
				ready_slot(SLOT_100MS);
				odd_ctr = '0;
			end
		end else if (phase_ctr[1]) begin
			two_ctr = two_ctr + 5'd1;
			ready_slot(SLOT_2MSA);
			if (two_ctr >= FIFTY_LIMIT) begin
				ready_slot(SLOT_50MS);
				two_ctr = '0;
			end
		end else begin
			four_ctr = four_ctr + 3'd1;
			ready_slot(SLOT_2MSB);
			if (four_ctr >= TEN_LIMIT) begin
				ready_slot(SLOT_10MS);
				four_ctr = '0;
			end
		end
	endfunction

	function automatic sched_result_t apply_event(input logic [2:0] op, input logic [3:0] slot);
		sched_result_t r;
		logic          hit;
		int            pick;
		hit  = 1'b0;
		pick = 0;
		case (op)
			MODE_TICK: begin
				advance_tick();
			end
			MODE_DISPATCH: begin
				if (running_slot == BKG_TASK) begin
					for (int i = int'(sweep_ptr); i < slots_active() && !hit; i++) begin
						if (slot_state[i] == ST_READY && cfg_handlers[i]) begin
							hit           = 1'b1;
							pick          = i;
							running_slot  = 5'(i);
							slot_state[i] = ST_RUNNING;
							run_ctr[i]    = run_ctr[i] + 8'd1;
							sweep_ptr     = 5'(i + 1);
						end
					end
					if (!hit)
						sweep_ptr = '0;
				end
			end
			MODE_DONE: begin
				if (running_slot != BKG_TASK) begin
					slot_state[running_slot[3:0]] = ST_SUSPENDED;
					running_slot = BKG_TASK;
				end
			end
			MODE_ACTIVATE: begin
				if (int'(slot) < slots_active())
					slot_state[slot] = ST_READY;
			end
			MODE_HALT: begin
				sched_status = STATUS_HALTED;
			end
			default: begin
			end
		endcase
		if (hit)
			dispatch_hits++;
		r.found    = hit;
		r.task_id  = hit ? 4'(pick) : 4'd0;
		r.runs     = hit ? run_ctr[pick] : 8'd0;
		r.running  = running_slot;
		r.overload = overload_bits;
		r.status   = sched_status;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 50)
			$display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Sender: bursts of random length, separated by random gaps when set to be bursty.
	int           burst_left = 0;
	int           gap_left   = 0;
	sched_event_t next_event;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			mode       <= MODE_TICK;
			task_index <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (item_valid && item_ready)
				expected_results.push_back(apply_event(mode, task_index));
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					gap_left   <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					next_event = pending_events.pop_front();
					item_valid <= 1'b1;
					mode       <= next_event.op;
					task_index <= next_event.slot;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left   <= (sender_bursty && $urandom_range(0, 3) != 0) ?
							$urandom_range(1, 8) : 0;
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: rotating ready pattern, reloaded on counter wrap, plus long holds on request.
	logic [31:0] ready_pat;
	logic [5:0]  pat_age;
	int          hold_left;
	int          holds_served;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_pat    <= '1;
			pat_age      <= '0;
			hold_left    <= 0;
			holds_served <= 0;
		end else begin
			pat_age <= pat_age + 6'd1;
			if (holds_served != hold_requests) begin
				holds_served <= hold_requests;
				hold_left    <= LONG_HOLD;
				result_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ready_pat[0] | ~receiver_stalls;
				if (pat_age == '0)
					ready_pat <= (($urandom_range(0, 2) == 0) ? ($urandom & $urandom) :
						($urandom | $urandom)) | 32'h1;
				else
					ready_pat <= {ready_pat[0], ready_pat[31:1]};
			end
		end
	end

	sched_result_t want;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected, running_task", running_task, 0);
			end else begin
				want = expected_results.pop_front();
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (dispatched_task !== want.task_id)
					report_mismatch("dispatched_task", dispatched_task, want.task_id);
				if (dispatched_run_count !== want.runs)
					report_mismatch("dispatched_run_count", dispatched_run_count, want.runs);
				if (running_task !== want.running)
					report_mismatch("running_task", running_task, want.running);
				if (overload_mask !== want.overload)
					report_mismatch("overload_mask", overload_mask, want.overload);
				if (scheduler_status !== want.status)
					report_mismatch("scheduler_status", scheduler_status, want.status);
			end
		end
	end

	task automatic push_event(input logic [2:0] op, input logic [3:0] slot);
		sched_event_t e;
		e.op   = op;
		e.slot = slot;
		pending_events.push_back(e);
		if (op <= MODE_HALT)
			events_queued++;
	endtask

	// Mostly well-formed frames: a few ticks, then dispatch and done rounds.
	task automatic queue_traffic(input int count, input int tick_max);
		int start;
		start = events_queued;
		while (events_queued - start < count) begin
			if ($urandom_range(0, 4) == 0) begin
				push_event(3'($urandom_range(0, MODE_SPARE_LAST)), 4'($urandom));
			end else begin
				repeat ($urandom_range(1, tick_max))
					push_event(MODE_TICK, 4'($urandom));
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 4) == 0)
						push_event(MODE_ACTIVATE, 4'($urandom));
					push_event(MODE_DISPATCH, 4'($urandom));
					if ($urandom_range(0, 6) != 0)
						push_event(MODE_DONE, 4'($urandom));
				end
				if ($urandom_range(0, 40) == 0)
					push_event(MODE_HALT, 4'($urandom));
			end
		end
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drain();
		while (pending_events.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [4:0] n, input logic [15:0] handlers, input int count,
		input int tick_max, input logic bursty, input logic stalls, input logic long_hold);
		drain();
		apb_write({REG_NUM_TASKS, 2'b00}, DATA_W'(n));
		cfg_slots = n;
		apb_write({REG_HANDLER, 2'b00}, DATA_W'(handlers));
		cfg_handlers = handlers;
		sender_bursty   <= bursty;
		receiver_stalls <= stalls;
		settings_run++;
		if (long_hold)
			hold_requests <= hold_requests + 1;
		queue_traffic(count, tick_max);
	endtask

	initial begin
		clear_schedule();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_bursty   <= 1'b0;
		receiver_stalls <= 1'b1;
		push_event(MODE_DONE, 4'd0);
		push_event(MODE_DISPATCH, 4'd0);
		push_event(MODE_ACTIVATE, 4'd15);
		push_event(MODE_ACTIVATE, 4'd5);
		push_event(MODE_ACTIVATE, 4'd0);
		push_event(MODE_DISPATCH, 4'd0);
		push_event(MODE_DISPATCH, 4'd15);
		push_event(MODE_ACTIVATE, 4'd0);
		push_event(MODE_TICK, 4'd0);
		push_event(MODE_DONE, 4'd0);
		push_event(MODE_DISPATCH, 4'd0);
		push_event(MODE_TICK, 4'd15);
		push_event(MODE_DONE, 4'd0);
		push_event(MODE_DISPATCH, 4'd0);
		push_event(MODE_DISPATCH, 4'd0);
		push_event(MODE_SPARE_FIRST, 4'd10);
		push_event(MODE_SPARE_FIRST + 3'd1, 4'd0);
		push_event(MODE_SPARE_LAST, 4'd15);
		push_event(MODE_HALT, 4'd0);
		push_event(MODE_TICK, 4'd0);
		push_event(MODE_TICK, 4'd0);
		push_event(MODE_DONE, 4'd0);
		push_event(MODE_DISPATCH, 4'd0);
		push_event(MODE_HALT, 4'd15);

		run_phase(5'd16, 16'hFFFF, 90, 2, 1'b0, 1'b1, 1'b1);
		run_phase(5'd1, 16'h0001, 60, 2, 1'b0, 1'b0, 1'b0);
		run_phase(5'd16, 16'h0000, 50, 2, 1'b1, 1'b1, 1'b0);
		run_phase(5'd31, 16'hAAAA, 70, 3, 1'($urandom), 1'($urandom), 1'b0);
		run_phase(5'd17, 16'h5555, 70, 3, 1'($urandom), 1'($urandom), 1'b0);
		run_phase(5'd6, 16'hFFFF, 180, 6, 1'b1, 1'b1, 1'b0);
		run_phase(5'($urandom_range(1, 16)), 16'($urandom), 70, 3, 1'b1, 1'($urandom), 1'b0);
		run_phase(5'd16, 16'h8001, 60, 3, 1'($urandom), 1'b1, 1'b0);
		drain();

		$display("Checked %0d results over %0d register settings: %0d ticks, %0d tasks dispatched.",
			results_checked, settings_run, ticks_applied, dispatch_hits);
		$display("Overload flags at the end: %04h, final status %0d.", overload_bits, sched_status);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timed out with %0d results still expected.", expected_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
